// ===== hw/rtl/hwrs_pkg.sv =====
`default_nettype none
package hwrs_pkg;

    localparam int CFG_W     = 11;
    localparam int LIMIT_W   = 17;
    localparam int SAMPLE_W  = 64;
    localparam int INDEX_W   = 16;

    localparam logic [CFG_W-1:0]    CFG_RESET  = 11'd1024;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] sample_value;
        logic [INDEX_W-1:0]  bucket_index;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] bucket_count;
        logic [SAMPLE_W-1:0] sample_count;
        logic [SAMPLE_W-1:0] sample_sum;
        logic [SAMPLE_W-1:0] smallest_sample;
        logic [SAMPLE_W-1:0] largest_sample;
        logic [SAMPLE_W-1:0] overflow_count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep_step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_clear;
        logic sweep_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/histogram_with_running_stats_top.sv =====
// Result: a transaction is captured in IDLE, where the bucket read is issued; in EXEC the
//   bucket is updated and the result registered, once the output slot is free.
// Transactions: one is in flight at a time, set by the read-modify-write through the
//   bucket memory's single registered read port. A clear adds a sweep of all NUM_BUCKETS buckets.
// Reset: synchronous, active low; afterwards the bucket memory is swept to zero entry by
//   entry, during which the input stalls (configuration writes still taken).
`default_nettype none
module histogram_with_running_stats_top
    import hwrs_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_in_item         i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  wire logic             i_out_stall,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    hwrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    hwrs_dp #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/hwrs_ram.sv =====
`default_nettype none
module hwrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hwrs_ctrl.sv =====
`default_nettype none
module hwrs_ctrl
    import hwrs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall,
    output logic         o_out_valid
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_SWEEP: o_cmd.sweep_step = 1'b1;
            ST_IDLE:  o_cmd.capture    = i_in_valid;
            ST_EXEC:  o_cmd.exec       = out_free;
            default:  o_cmd            = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    if (i_sts.sweep_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    // hold the finished item until the output slot frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= i_sts.item_clear ? ST_SWEEP : ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hwrs_dp.sv =====
`default_nettype none
module hwrs_dp
    import hwrs_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire t_in_item         i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output t_out_item             o_result
);

    localparam int ADDR_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(NUM_BUCKETS - 1);
    localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(NUM_BUCKETS);

    logic [CFG_W-1:0]    r_cfg;
    logic [1:0]          r_mode;
    logic [SAMPLE_W-1:0] r_sample;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_in_range;
    logic [ADDR_W-1:0]   r_sweep_addr;

    logic [SAMPLE_W-1:0] r_count, r_sum, r_min, r_max, r_ovf;
    logic [SAMPLE_W-1:0] n_count, n_sum, n_min, n_max, n_ovf, n_bucket;
    t_out_item           r_result;

    logic [LIMIT_W-1:0]  limit;
    logic                in_range;
    logic [SAMPLE_W-1:0] rdata;
    logic [SAMPLE_W-1:0] bucket_inc;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                item_add;

    // a register value beyond the store size acts as the store size
    assign limit = (LIMIT_W'(r_cfg) > MAX_LIMIT) ? MAX_LIMIT : LIMIT_W'(r_cfg);
    assign in_range = LIMIT_W'(i_item.bucket_index) < limit;

    assign item_add   = (r_mode == MODE_ADD);
    assign bucket_inc = rdata + SAMPLE_W'(1);

    assign o_sts.item_clear = (r_mode == MODE_CLEAR);
    assign o_sts.sweep_last = (r_sweep_addr == LAST_ADDR);
    assign o_result         = r_result;

    always_comb begin
        if (i_cmd.sweep_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.exec && item_add && r_in_range;
            ram_waddr = r_idx;
            ram_wdata = bucket_inc;
        end
    end

    hwrs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_item.bucket_index[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count  = r_count;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        n_ovf    = r_ovf;
        n_bucket = '0;
        unique case (r_mode)
            MODE_ADD: begin
                n_count = r_count + SAMPLE_W'(1);
                n_sum   = r_sum + r_sample;
                n_min   = (r_sample < r_min) ? r_sample : r_min;
                n_max   = (r_sample > r_max) ? r_sample : r_max;
                if (r_in_range) begin
                    n_bucket = bucket_inc;
                end else begin
                    n_ovf = r_ovf + SAMPLE_W'(1);
                end
            end
            MODE_READ: begin
                if (r_in_range) begin
                    n_bucket = rdata;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
                n_sum   = '0;
                n_min   = SAMPLE_MAX;
                n_max   = '0;
                n_ovf   = '0;
            end
            default: n_bucket = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_item.mode;
            r_sample   <= i_item.sample_value;
            r_idx      <= i_item.bucket_index[ADDR_W-1:0];
            r_in_range <= in_range;
        end
        if (i_cmd.exec) begin
            r_result.bucket_count    <= n_bucket;
            r_result.sample_count    <= n_count;
            r_result.sample_sum      <= n_sum;
            r_result.smallest_sample <= n_min;
            r_result.largest_sample  <= n_max;
            r_result.overflow_count  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= CFG_RESET;
            r_sweep_addr <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_min        <= SAMPLE_MAX;
            r_max        <= '0;
            r_ovf        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // wrap the sweep address so the next pass starts at zero
            if (i_cmd.sweep_step) begin
                r_sweep_addr <= o_sts.sweep_last ? '0 : r_sweep_addr + ADDR_W'(1);
            end
            if (i_cmd.exec) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_min   <= n_min;
                r_max   <= n_max;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hwrs_checker.sv =====
`default_nettype none
module hwrs_checker
    import hwrs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire t_out_item        o_out_data,
    input wire logic             i_out_stall
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset starts the clearing sweep with nothing pending
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input open or result pending after reset");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted back to back");

    // with samples present the minimum cannot exceed the maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.sample_count != '0) |->
            o_out_data.smallest_sample <= o_out_data.largest_sample)
        else $error("smallest sample above largest sample");

endmodule

bind histogram_with_running_stats_top hwrs_checker u_hwrs_checker (.*);
`default_nettype wire

// ===== sim/histogram_with_running_stats_top_tb.sv =====
`timescale 1ns / 1ps
module histogram_with_running_stats_top_tb;
    import hwrs_pkg::*;

    localparam int NUM_BUCKETS = 1024;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 212;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_in_item         item;
        t_out_item        want;
        logic [CFG_W-1:0] limit;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    t_in_item         i_in_data = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_data;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    // Shadow copy of the block's state
    logic [SAMPLE_W-1:0] bucket_shadow [NUM_BUCKETS];
    logic [SAMPLE_W-1:0] count_shadow;
    logic [SAMPLE_W-1:0] sum_shadow;
    logic [SAMPLE_W-1:0] min_shadow;
    logic [SAMPLE_W-1:0] max_shadow;
    logic [SAMPLE_W-1:0] overflow_shadow;
    logic [CFG_W-1:0]    limit_shadow;

    t_out_item pending_results [$];
    t_dir_row  directed [$];
    int        err_cnt = 0;
    int        burst_left = 1;
    int        stall_tick = 0;
    int        stall_style = 0;

    histogram_with_running_stats_top #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void clear_shadow();
        foreach (bucket_shadow[b]) bucket_shadow[b] = '0;
        count_shadow    = '0;
        sum_shadow      = '0;
        min_shadow      = SAMPLE_MAX;
        max_shadow      = '0;
        overflow_shadow = '0;
    endfunction

    function automatic int unsigned active_buckets();
        return (limit_shadow > NUM_BUCKETS) ? NUM_BUCKETS : limit_shadow;
    endfunction

    // Apply one transaction to the shadow state and return the result it yields
    function automatic t_out_item histogram_step(t_in_item it);
        t_out_item   r;
        int unsigned idx;
        bit          hit;
        idx = it.bucket_index;
        hit = idx < active_buckets();
        r   = '0;
        case (it.mode)
            MODE_ADD: begin
                count_shadow = count_shadow + 64'd1;
                sum_shadow   = sum_shadow + it.sample_value;
                if (it.sample_value > max_shadow) max_shadow = it.sample_value;
                if (it.sample_value < min_shadow) min_shadow = it.sample_value;
                if (hit) begin
                    bucket_shadow[idx] = bucket_shadow[idx] + 64'd1;
                    r.bucket_count     = bucket_shadow[idx];
                end else begin
                    overflow_shadow = overflow_shadow + 64'd1;
                end
            end
            MODE_READ: begin
                if (hit) r.bucket_count = bucket_shadow[idx];
            end
            MODE_CLEAR: begin
                clear_shadow();
            end
            default: ;
        endcase
        r.sample_count    = count_shadow;
        r.sample_sum      = sum_shadow;
        r.smallest_sample = min_shadow;
        r.largest_sample  = max_shadow;
        r.overflow_count  = overflow_shadow;
        return r;
    endfunction

    function automatic t_out_item stats(logic [63:0] bc, logic [63:0] cnt, logic [63:0] sum,
                                        logic [63:0] mn, logic [63:0] mx, logic [63:0] ovf);
        return {bc, cnt, sum, mn, mx, ovf};
    endfunction

    function automatic t_dir_row typed_row(logic [1:0] mode, logic [63:0] sample,
                                           logic [15:0] idx, t_out_item want);
        t_dir_row r;
        r.kind  = ROW_TYPED;
        r.item  = {mode, sample, idx};
        r.want  = want;
        r.limit = '0;
        return r;
    endfunction

    function automatic t_dir_row item_row(logic [1:0] mode, logic [63:0] sample,
                                          logic [15:0] idx);
        t_dir_row r;
        r      = typed_row(mode, sample, idx, '0);
        r.kind = ROW_PREDICTED;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_W-1:0] v);
        t_dir_row r;
        r       = typed_row(MODE_READ, '0, '0, '0);
        r.kind  = ROW_CFG;
        r.limit = v;
        return r;
    endfunction

    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = histogram_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid between bursts; some bursts run long with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Register writes only once every outstanding result has drained
    task automatic write_limit(logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_shadow = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            $error("%s: expected %h, actual %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ((stall_tick % 7) < 3);
            default: i_out_stall <= ($urandom_range(0, 9) < 6);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $error("result with no transaction pending");
            end else begin
                want = pending_results.pop_front();
                check_field("bucket_count", want.bucket_count, o_out_data.bucket_count);
                check_field("sample_count", want.sample_count, o_out_data.sample_count);
                check_field("sample_sum", want.sample_sum, o_out_data.sample_sum);
                check_field("smallest_sample", want.smallest_sample,
                            o_out_data.smallest_sample);
                check_field("largest_sample", want.largest_sample, o_out_data.largest_sample);
                check_field("overflow_count", want.overflow_count, o_out_data.overflow_count);
            end
        end
    end

    initial begin
        t_in_item         it;
        int unsigned      pick;
        int unsigned      act;
        logic [CFG_W-1:0] phase_limit [PHASES];

        clear_shadow();
        limit_shadow = CFG_RESET;

        phase_limit[0] = 11'd1024;
        phase_limit[1] = 11'd1;
        phase_limit[2] = 11'($urandom_range(2, NUM_BUCKETS - 1));
        phase_limit[3] = 11'd0;
        phase_limit[4] = 11'd2047;
        phase_limit[5] = 11'd8;
        phase_limit[6] = 11'($urandom);
        phase_limit[7] = 11'd1024;

        // Fresh out of reset, then the extremes of sample and index
        directed.push_back(typed_row(MODE_READ, 64'd0, 16'd0,
                                     stats(0, 0, 0, SAMPLE_MAX, 0, 0)));
        directed.push_back(typed_row(MODE_SPARE, 64'h1234, 16'd5,
                                     stats(0, 0, 0, SAMPLE_MAX, 0, 0)));
        directed.push_back(typed_row(MODE_ADD, 64'd0, 16'd0, stats(1, 1, 0, 0, 0, 0)));
        directed.push_back(typed_row(MODE_ADD, SAMPLE_MAX, 16'd1023,
                                     stats(1, 2, SAMPLE_MAX, 0, SAMPLE_MAX, 0)));
        directed.push_back(typed_row(MODE_ADD, 64'd1, 16'd1024,
                                     stats(0, 3, 0, 0, SAMPLE_MAX, 1)));
        directed.push_back(typed_row(MODE_ADD, 64'h8000_0000_0000_0000, 16'hFFFF,
                                     stats(0, 4, 64'h8000_0000_0000_0000, 0, SAMPLE_MAX, 2)));
        directed.push_back(item_row(MODE_ADD, 64'h5555_5555_5555_5555, 16'd0));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'd0));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'hFFFF));
        // Register at zero: everything overflows, reads answer nothing
        directed.push_back(cfg_row(11'd0));
        directed.push_back(item_row(MODE_ADD, 64'd7, 16'd0));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'd0));
        // Shrunk register keeps bucket contents
        directed.push_back(cfg_row(11'd1));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'd0));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'd1));
        directed.push_back(item_row(MODE_ADD, 64'hFFFF_0000, 16'd1));
        // Register beyond the bucket count saturates
        directed.push_back(cfg_row(11'd2047));
        directed.push_back(item_row(MODE_READ, 64'd0, 16'd1023));
        directed.push_back(item_row(MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 16'd1023));
        // Clear with most buckets out of use must still wipe them all
        directed.push_back(cfg_row(11'd1));
        directed.push_back(typed_row(MODE_CLEAR, 64'd9, 16'd3,
                                     stats(0, 0, 0, SAMPLE_MAX, 0, 0)));
        directed.push_back(cfg_row(11'd1024));
        directed.push_back(typed_row(MODE_READ, 64'hDEAD, 16'd1023,
                                     stats(0, 0, 0, SAMPLE_MAX, 0, 0)));
        directed.push_back(typed_row(MODE_ADD, 64'd3, 16'd1023, stats(1, 1, 3, 3, 3, 0)));
        directed.push_back(item_row(MODE_SPARE, SAMPLE_MAX, 16'd1023));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                write_limit(directed[k].limit);
            end else begin
                send_item(directed[k].item, directed[k].kind == ROW_TYPED, directed[k].want);
                pace_sender();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p]);
            act = active_buckets();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      it.mode = MODE_ADD;
                else if (pick < 95) it.mode = MODE_READ;
                else if (pick < 96) it.mode = MODE_CLEAR;
                else                it.mode = MODE_SPARE;

                pick = $urandom_range(0, 99);
                if (pick < 8)       it.sample_value = '0;
                else if (pick < 16) it.sample_value = SAMPLE_MAX;
                else if (pick < 40) it.sample_value = 64'($urandom_range(0, 1000));
                else                it.sample_value = {$urandom, $urandom};

                // Favour a few hot buckets so back-to-back updates hit the same entry
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    it.bucket_index = 16'($urandom_range(0, 7));
                else if (pick < 80)
                    it.bucket_index = 16'($urandom_range(0, NUM_BUCKETS + 64));
                else if (pick < 90)
                    it.bucket_index = (act == 0) ? 16'd0 : 16'(act - 1 + $urandom_range(0, 1));
                else
                    it.bucket_index = 16'($urandom);

                send_item(it, 1'b0, '0);
                pace_sender();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
